>>> rtl/core/tclfu_pkg.sv
// shared types and constants for the translation cache
package tclfu_pkg;

    localparam logic [1:0] OP_LOOKUP = 2'd0;
    localparam logic [1:0] OP_STORE  = 2'd1;
    localparam logic [1:0] OP_INVAL  = 2'd2;
    localparam logic [1:0] OP_FLUSH  = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_MISS    = 2'd1;
    localparam logic [1:0] ST_BAD_ARG = 2'd2;

    localparam int IN_BITS  = 358;
    localparam int IN_BYTES = 45;
    localparam int OUT_BITS = 288;
    localparam int OUT_BYTES = 36;

    localparam logic [31:0] USES_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [19:0] native_size;
        logic [63:0] native_handle;
        logic [31:0] config_flags;
        logic [31:0] translator_version;
        logic [31:0] ov_version;
        logic [63:0] code_hash;
        logic [63:0] guest_pc;
        logic [31:0] module_id;
        logic [7:0]  target_arch;
        logic [7:0]  source_arch;
        logic [1:0]  operation;
    } item_t;

    typedef struct packed {
        logic [63:0] allocated_bytes;
        logic [31:0] invalidation_count;
        logic [31:0] miss_count;
        logic [31:0] hit_count;
        logic [31:0] lookup_count;
        logic [4:0]  active_entries;
        logic [4:0]  invalidated;
        logic [19:0] out_size;
        logic [63:0] out_handle;
        logic [1:0]  status;
    } result_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic exec;
    } cmd_t;

endpackage

>>> rtl/core/tclfu_ctrl.sv
// controller: accepts a beat, runs match then update, holds the result
module tclfu_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    output logic            m_tvalid,
    input  logic            m_tready,
    output tclfu_pkg::cmd_t cmd
);
    import tclfu_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_OUT  = 2'd2;

    logic [1:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                    state_next = S_EXEC;
            end
            S_EXEC:
                state_next = S_OUT;
            S_OUT:
            begin
                if (m_tready)
                    state_next = s_tvalid ? S_EXEC : S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign s_tready = (state_reg == S_IDLE) || (state_reg == S_OUT && m_tready);
    assign m_tvalid = (state_reg == S_OUT);
    assign cmd.load = s_tvalid && s_tready;
    assign cmd.exec = (state_reg == S_EXEC);

endmodule

>>> rtl/core/tclfu_dp.sv
// datapath: entry store, parallel match, victim select and statistics
module tclfu_dp #(
    parameter int ENTRIES = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  tclfu_pkg::cmd_t    cmd,
    input  tclfu_pkg::item_t   item_in,
    output tclfu_pkg::result_t result
);
    import tclfu_pkg::*;

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    item_t item_reg;

    logic [ENTRIES-1:0] valid_reg;
    logic [15:0] arch_mem [ENTRIES];
    logic [31:0] module_mem [ENTRIES];
    logic [63:0] pc_mem [ENTRIES];
    logic [63:0] hash_mem [ENTRIES];
    logic [63:0] vers_mem [ENTRIES];
    logic [31:0] flags_mem [ENTRIES];
    logic [63:0] handle_mem [ENTRIES];
    logic [19:0] size_mem [ENTRIES];
    logic [31:0] uses_reg [ENTRIES];
    logic [CW-1:0] total_reg;
    logic [31:0] lookups_reg, hits_reg, misses_reg, inval_reg;
    logic [63:0] bytes_reg;

    logic [1:0]  status_reg, status_next;
    logic [63:0] handle_reg, handle_next;
    logic [19:0] size_reg, size_next;
    logic [4:0]  cleared_reg, cleared_next;

    logic [15:0] arch;
    logic [63:0] vers;
    logic [ENTRIES-1:0] full_hit, key_hit, stale;
    logic [IW-1:0] hit_idx, key_idx, free_idx, victim_idx, slot;
    logic any_hit, any_key, any_free, bad;
    logic [CW-1:0] cleared;

    assign arch = {item_reg.source_arch, item_reg.target_arch};
    assign vers = {item_reg.ov_version, item_reg.translator_version};
    assign bad  = (item_reg.native_size == '0) || (item_reg.native_handle == '0);

    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            key_hit[i] = valid_reg[i] && arch_mem[i] == arch
                && module_mem[i] == item_reg.module_id && pc_mem[i] == item_reg.guest_pc;
            full_hit[i] = key_hit[i] && hash_mem[i] == item_reg.code_hash
                && vers_mem[i] == vers && flags_mem[i] == item_reg.config_flags;
            stale[i] = valid_reg[i]
                && (vers_mem[i] != vers || flags_mem[i] != item_reg.config_flags);
        end
    end

    // priority encoders, lowest index wins
    always_comb
    begin
        hit_idx = '0; key_idx = '0; free_idx = '0;
        any_hit = 1'b0; any_key = 1'b0; any_free = 1'b0;
        cleared = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (full_hit[i]) begin hit_idx = IW'(i); any_hit = 1'b1; end
            if (key_hit[i])  begin key_idx = IW'(i); any_key = 1'b1; end
            if (!valid_reg[i]) begin free_idx = IW'(i); any_free = 1'b1; end
        end
        for (int i = 0; i < ENTRIES; i++)
            cleared = cleared + CW'(stale[i]);
    end

    // minimum tree for the victim, first index on ties
    localparam int LEAVES = 1 << IW;
    logic [31:0]   tv [2*LEAVES];
    logic [IW-1:0] ti [2*LEAVES];
    always_comb
    begin
        for (int i = 0; i < LEAVES; i++)
        begin
            tv[LEAVES+i] = (i < ENTRIES) ? uses_reg[i < ENTRIES ? i : 0] : USES_MAX;
            ti[LEAVES+i] = IW'(i);
        end
        for (int n = LEAVES - 1; n >= 1; n--)
        begin
            if (tv[2*n+1] < tv[2*n])
            begin
                tv[n] = tv[2*n+1]; ti[n] = ti[2*n+1];
            end
            else
            begin
                tv[n] = tv[2*n]; ti[n] = ti[2*n];
            end
        end
        tv[0] = tv[1]; ti[0] = ti[1];
        victim_idx = ti[1];
    end

    assign slot = any_key ? key_idx : (any_free ? free_idx : victim_idx);

    always_comb
    begin
        status_next  = ST_OK;
        handle_next  = '0;
        size_next    = '0;
        cleared_next = '0;
        case (item_reg.operation)
            OP_LOOKUP:
            begin
                if (any_hit)
                begin
                    handle_next = handle_mem[hit_idx];
                    size_next   = size_mem[hit_idx];
                end
                else
                    status_next = ST_MISS;
            end
            OP_STORE:
            begin
                if (bad)
                    status_next = ST_BAD_ARG;
            end
            OP_INVAL:
                cleared_next = 5'(cleared);
            default:
                status_next = ST_OK;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            item_reg <= item_in;
        if (cmd.exec && item_reg.operation == OP_STORE && !bad)
        begin
            arch_mem[slot]   <= arch;
            module_mem[slot] <= item_reg.module_id;
            pc_mem[slot]     <= item_reg.guest_pc;
            hash_mem[slot]   <= item_reg.code_hash;
            vers_mem[slot]   <= vers;
            flags_mem[slot]  <= item_reg.config_flags;
            handle_mem[slot] <= item_reg.native_handle;
            size_mem[slot]   <= item_reg.native_size;
        end
        if (cmd.exec)
        begin
            status_reg  <= status_next;
            handle_reg  <= handle_next;
            size_reg    <= size_next;
            cleared_reg <= cleared_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            total_reg   <= '0;
            lookups_reg <= '0;
            hits_reg    <= '0;
            misses_reg  <= '0;
            inval_reg   <= '0;
            bytes_reg   <= '0;
            for (int i = 0; i < ENTRIES; i++)
                uses_reg[i] <= '0;
        end
        else if (cmd.exec)
        begin
            case (item_reg.operation)
                OP_LOOKUP:
                begin
                    lookups_reg <= lookups_reg + 32'd1;
                    if (any_hit)
                    begin
                        hits_reg <= hits_reg + 32'd1;
                        if (uses_reg[hit_idx] != USES_MAX)
                            uses_reg[hit_idx] <= uses_reg[hit_idx] + 32'd1;
                    end
                    else
                        misses_reg <= misses_reg + 32'd1;
                end
                OP_STORE:
                begin
                    if (!bad)
                    begin
                        valid_reg[slot] <= 1'b1;
                        uses_reg[slot]  <= 32'd1;
                        bytes_reg <= bytes_reg + 64'(item_reg.native_size);
                        if (!any_key && any_free)
                            total_reg <= total_reg + CW'(1);
                    end
                end
                OP_INVAL:
                begin
                    valid_reg <= valid_reg & ~stale;
                    total_reg <= total_reg - cleared;
                    inval_reg <= inval_reg + 32'(cleared);
                end
                default:
                begin
                    valid_reg <= '0;
                    total_reg <= '0;
                    bytes_reg <= '0;
                end
            endcase
        end
    end

    assign result.status             = status_reg;
    assign result.out_handle         = handle_reg;
    assign result.out_size           = size_reg;
    assign result.invalidated        = cleared_reg;
    assign result.active_entries     = 5'(total_reg);
    assign result.lookup_count       = lookups_reg;
    assign result.hit_count          = hits_reg;
    assign result.miss_count         = misses_reg;
    assign result.invalidation_count = inval_reg;
    assign result.allocated_bytes    = bytes_reg;

endmodule

>>> rtl/core/translation_cache_lfu.sv
// top level of the fully associative translation cache with lfu replacement
// the input beat is registered, then match and update run and the result is registered
// only one item is in flight; no new input beat is taken while a result is pending
// the output beat holds until taken; the next input beat is taken in the same cycle
// reset: asynchronous active low, clears all entries, counts and statistics
module translation_cache_lfu #(
    parameter int ENTRIES = 16
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // operation, source_arch, target_arch, module_id, guest_pc, code_hash, ov_version,
    // translator_version, config_flags, native_handle, native_size
    input  logic [tclfu_pkg::IN_BYTES*8-1:0]    s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // status, out_handle, out_size, invalidated, active_entries, lookup_count,
    // hit_count, miss_count, invalidation_count, allocated_bytes
    output logic [tclfu_pkg::OUT_BYTES*8-1:0]   m_tdata
);
    import tclfu_pkg::*;

    cmd_t    cmd;
    result_t result;

    tclfu_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    tclfu_dp #(.ENTRIES(ENTRIES)) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .item_in (item_t'(s_tdata[IN_BITS-1:0])),
        .result  (result)
    );

    assign m_tdata = result;

endmodule

>>> rtl/core/tclfu_checker.sv
// port-level checks for the translation cache
module tclfu_checker
(
    input logic                                clk,
    input logic                                rst_n,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [tclfu_pkg::OUT_BYTES*8-1:0]   m_tdata
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output beat dropped or changed while stalled");

    a_no_take_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while result stalled");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> ##1 m_tvalid)
        else $error("no result two cycles after input beat");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[1:0] != 2'd3)
        else $error("illegal status code");

endmodule

bind translation_cache_lfu tclfu_checker u_tclfu_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
